// ===== hdl/sfbp_pkg.sv =====
package sfbp_pkg;

   // Pool geometry.
   localparam int NUM_LISTS   = 64;
   localparam int LIST_DEPTH  = 64;
   localparam int OFFSET_BITS = 16;

   // Derived widths.
   localparam int CLASS_W     = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int PTR_W       = $clog2(LIST_DEPTH);
   localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
   localparam int STORE_DEPTH = NUM_LISTS * LIST_DEPTH;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   // Operation codes.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_TAKE   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // Status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_NOFIT = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [6:0]  size_class;
      logic [15:0] free_offset;
      logic [15:0] chunk_tag;
      logic [15:0] zone_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted_offset;
      logic [6:0]  granted_size;
      logic [15:0] granted_chunk;
      logic [15:0] granted_zone;
      logic        pool_empty;
   } rsp_type;

   // One entry of the per-class pointer memory.
   typedef struct packed {
      logic [PTR_W-1:0] head;
      logic [PTR_W-1:0] tail;
      logic [CNT_W-1:0] count;
   } ptr_type;

   // Class selection handed from the bitmap logic to the control.
   typedef struct packed {
      logic               found;
      logic [CLASS_W-1:0] cls;
   } pick_type;

   // Ring pointer advance with wrap.
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(LIST_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

// ===== hdl/sfbp_ram.sv =====
module sfbp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sfbp_class_pick.sv =====
module sfbp_class_pick
   import sfbp_pkg::*;
(
   input  logic [1:0]           opcode,
   input  logic [6:0]           size_class,
   input  logic [NUM_LISTS-1:0] nonempty_map,
   output pick_type             pick
);

   logic [6:0]           need;
   logic [NUM_LISTS-1:0] fit_map;
   logic                 fit_any;
   logic [CLASS_W-1:0]   fit_cls;

   // A take request for class zero counts as a request for class one.
   assign need = (size_class == 7'd0) ? 7'd1 : size_class;

   // Mask out the classes below the request.
   always_comb begin
      for (int i = 0; i < NUM_LISTS; i++) begin
         fit_map[i] = nonempty_map[i] && ((8'(i) + 8'd1) >= {1'b0, need});
      end
   end

   // Lowest set bit is the smallest fitting class.
   always_comb begin
      fit_cls = '0;
      for (int i = NUM_LISTS - 1; i >= 0; i--) begin
         if (fit_map[i]) begin
            fit_cls = CLASS_W'(i);
         end
      end
   end

   assign fit_any = |fit_map;

   // Insert uses its own class when it is in range; take uses the best fit.
   always_comb begin
      if (opcode == OP_TAKE) begin
         pick.found = fit_any;
         pick.cls   = fit_cls;
      end else begin
         pick.found = (size_class != 7'd0) && ({1'b0, size_class} <= 8'(NUM_LISTS));
         pick.cls   = CLASS_W'(size_class - 7'd1);
      end
   end

endmodule

// ===== hdl/segregated_fit_block_pool.sv =====
// Segregated-fit free block pool.
// Transactions arrive on the req_ channel (req_valid, req_stall, req_data) and
// each one produces exactly one response transaction on the rsp_ channel
// (rsp_valid, rsp_stall, rsp_data), in order.
// Insert pushes a block offset onto the FIFO ring of its size class, take
// returns the head of the smallest non-empty class at or above the requested
// size, and clear empties every class. Each response carries a status and a
// flag telling whether the pool is empty afterwards.
// Insert, clear and failed takes build their response in the update state; a
// successful take goes on to a fetch state, since the ring entry is read only
// once the pointer memory has returned the head. One transaction is in flight
// at a time, so a new request is accepted only once the control is back in
// idle, which it enters as the response is registered.
// Reset empties all class lists at once through per-class valid bits; the ring
// storage itself is not cleared, and requests are stalled while reset is high.
// When the receiver stalls, the response stays in the output register and the
// next transaction may still be accepted; it then waits to finish until the
// output register is free.
module segregated_fit_block_pool
   import sfbp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_UPDATE = 2'd1;
   localparam logic [1:0] S_FETCH  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [1:0]           op_ff;
   logic [CLASS_W-1:0]   cls_ff;
   logic                 found_ff;
   logic [OFFSET_BITS-1:0] off_ff;
   logic [NUM_LISTS-1:0] map_ff, map_in;
   logic [NUM_LISTS-1:0] valid_ff, valid_in;
   logic [15:0]          owner_chunk_ff, owner_zone_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   logic                 out_free;
   logic                 finish;
   pick_type             pick;

   logic [$bits(ptr_type)-1:0] ptr_rd_raw;
   ptr_type              ptr_cur, ptr_new;
   logic                 ptr_wr_en;
   logic [STORE_AW-1:0]  store_base;
   logic                 store_wr_en, store_rd_en;
   logic [STORE_AW-1:0]  store_wr_addr, store_rd_addr;
   logic [OFFSET_BITS-1:0] store_rd_data;
   logic [31:0]          off_wide;
   logic [31:0]          got_wide;

   // Handshake.
   assign req_stall  = reset || (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Class selection from the bitmap.
   sfbp_class_pick u_pick (
      .opcode       (req_data.opcode),
      .size_class   (req_data.size_class),
      .nonempty_map (map_ff),
      .pick         (pick)
   );

   // Per-class head, tail and count.
   sfbp_ram #(
      .WIDTH ($bits(ptr_type)),
      .DEPTH (NUM_LISTS)
   ) u_ptr_ram (
      .clock   (clock),
      .wr_en   (ptr_wr_en),
      .wr_addr (cls_ff),
      .wr_data (ptr_new),
      .rd_en   (req_accept),
      .rd_addr (pick.cls),
      .rd_data (ptr_rd_raw)
   );

   // Ring entries of all classes.
   sfbp_ram #(
      .WIDTH (OFFSET_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (off_ff),
      .rd_en   (store_rd_en),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   // A class whose valid bit is clear reads as empty with zero pointers.
   assign ptr_cur = valid_ff[cls_ff] ? ptr_type'(ptr_rd_raw) : '0;

   assign store_base    = STORE_AW'(cls_ff) * STORE_AW'(LIST_DEPTH);
   assign store_wr_addr = store_base + STORE_AW'(ptr_cur.tail);
   assign store_rd_addr = store_base + STORE_AW'(ptr_cur.head);

   assign off_wide = 32'(req_data.free_offset);
   assign got_wide = 32'(store_rd_data);

   // Main control: pointer update, bitmap update and response assembly.
   always_comb begin
      state_in     = state_ff;
      map_in       = map_ff;
      valid_in     = valid_ff;
      ptr_new      = ptr_cur;
      ptr_wr_en    = 1'b0;
      store_wr_en  = 1'b0;
      store_rd_en  = 1'b0;
      finish       = 1'b0;
      rsp_data_in  = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (op_ff == OP_TAKE && found_ff) begin
               // Pop the head: read its entry, advance the head pointer and lower the count.
               store_rd_en   = 1'b1;
               ptr_wr_en     = 1'b1;
               ptr_new.head  = ptr_next(ptr_cur.head);
               if (ptr_cur.count != '0) begin
                  ptr_new.count = ptr_cur.count - CNT_W'(1);
               end
               if (ptr_new.count == '0) begin
                  map_in[cls_ff] = 1'b0;
               end
               valid_in[cls_ff] = 1'b1;
               state_in = S_FETCH;
            end else if (out_free) begin
               finish   = 1'b1;
               state_in = S_IDLE;
               case (op_ff)
                  OP_INSERT: begin
                     if (found_ff && (ptr_cur.count < CNT_W'(LIST_DEPTH))) begin
                        store_wr_en      = 1'b1;
                        ptr_wr_en        = 1'b1;
                        ptr_new.tail     = ptr_next(ptr_cur.tail);
                        ptr_new.count    = ptr_cur.count + CNT_W'(1);
                        valid_in[cls_ff] = 1'b1;
                        map_in[cls_ff]   = 1'b1;
                        rsp_data_in.status = STATUS_OK;
                     end else begin
                        rsp_data_in.status = STATUS_FULL;
                     end
                  end
                  OP_TAKE: begin
                     rsp_data_in.status = STATUS_NOFIT;
                  end
                  OP_CLEAR: begin
                     map_in   = '0;
                     valid_in = '0;
                     rsp_data_in.status = STATUS_OK;
                  end
                  default: begin
                     rsp_data_in.status = STATUS_OK;
                  end
               endcase
               rsp_data_in.pool_empty = (map_in == '0);
            end
         end
         S_FETCH: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = S_IDLE;
               rsp_data_in.status         = STATUS_OK;
               rsp_data_in.granted_offset = got_wide[15:0];
               rsp_data_in.granted_size   = 7'(cls_ff) + 7'd1;
               rsp_data_in.granted_chunk  = owner_chunk_ff;
               rsp_data_in.granted_zone   = owner_zone_ff;
               rsp_data_in.pool_empty     = (map_ff == '0);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register valid.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         map_ff         <= '0;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         owner_chunk_ff <= '0;
         owner_zone_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         map_ff       <= map_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // Chunk and zone are recorded by an insert into an empty pool.
         if (req_accept && req_data.opcode == OP_INSERT && map_ff == '0) begin
            owner_chunk_ff <= req_data.chunk_tag;
            owner_zone_ff  <= req_data.zone_id;
         end
      end
   end

   // Request and response payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= req_data.opcode;
         cls_ff   <= pick.cls;
         found_ff <= pick.found;
         off_ff   <= off_wide[OFFSET_BITS-1:0];
      end
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
